/* src/rcfs_pkg.sv */
package rcfs_pkg;

    // Array and field geometry.
    localparam int ARRAY_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(ARRAY_DEPTH);
    localparam int WIN_W       = ADDR_W + 1;
    localparam int POS_W       = 10;
    localparam int KEY_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int SUM_W       = 31;
    localparam int SQ_W        = 2 * COUNT_W;
    localparam int CFG_W       = 11;

    // Request codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ELEMENT_COUNT = 1'b0;

    // Reset value of element_count.
    localparam logic [CFG_W-1:0] ELEMENT_COUNT_RESET = CFG_W'(1024);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_step;
        logic step;
        logic read_count;
        logic square;
        logic update;
        logic load_write;
        logic respond;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_load;
        logic load_ok;
        logic bad;
        logic need_step;
    } dp_status_t;

endpackage

/* src/rcfs_ctrl.sv */
module rcfs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rcfs_pkg::dp_status_t status,
    output rcfs_pkg::dp_cmd_t    cmd,
    output logic                 busy
);
    import rcfs_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_CHECK  = 7'b0000100,
        ST_ADDR   = 7'b0001000,
        ST_KEY    = 7'b0010000,
        ST_CNT    = 7'b0100000,
        ST_LOADWR = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   upd_reg;
    logic   upd_next;

    // State register; reset starts the histogram clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            upd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upd_reg   <= upd_next;
        end
    end

    // Next state and datapath commands.
    // The update of one element happens in the cycle after ST_CNT, marked by upd_reg,
    // while the machine already sits in ST_CHECK again.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        upd_next   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (upd_reg)
                begin
                    // Finish the pending element before deciding again.
                    cmd.update = 1'b1;
                end
                else
                begin
                    priority if (status.is_load && !status.load_ok)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!status.is_load && status.bad)
                    begin
                        cmd.respond = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (status.need_step)
                    begin
                        state_next = ST_ADDR;
                    end
                    else if (status.is_load)
                    begin
                        state_next = ST_LOADWR;
                    end
                    else
                    begin
                        cmd.respond = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_ADDR:
            begin
                cmd.step   = 1'b1;
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                cmd.read_count = 1'b1;
                state_next     = ST_CNT;
            end
            ST_CNT:
            begin
                cmd.square = 1'b1;
                upd_next   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_LOADWR:
            begin
                cmd.load_write = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* src/rcfs_dp.sv */
module rcfs_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rcfs_pkg::dp_cmd_t           cmd,
    output rcfs_pkg::dp_status_t        status,
    input  logic [rcfs_pkg::CFG_W-1:0]  element_count,
    input  logic                        command,
    input  logic [rcfs_pkg::POS_W-1:0]  position,
    input  logic [rcfs_pkg::KEY_W-1:0]  key,
    input  logic [rcfs_pkg::POS_W-1:0]  left,
    input  logic [rcfs_pkg::POS_W-1:0]  right,
    output logic [rcfs_pkg::SUM_W-1:0]  cube_sum,
    output logic                        bad_query,
    output logic                        done
);
    import rcfs_pkg::*;

    localparam int KEY_SPACE = 1 << KEY_W;

    // Memories: stored keys and the histogram of keys in the window.
    logic [KEY_W-1:0]   elem_mem [ARRAY_DEPTH];
    logic [COUNT_W-1:0] count_mem [KEY_SPACE];

    // Window and running sum (control state).
    logic [WIN_W-1:0]  wl_reg, wl_next;
    logic [WIN_W-1:0]  wr_reg, wr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [KEY_W-1:0]  clr_reg;
    logic              done_reg;

    // Captured request.
    logic [WIN_W-1:0]  left_reg;
    logic [WIN_W-1:0]  end_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              is_load_reg;
    logic              load_ok_reg;
    logic              bad_reg;

    // Per-element pipeline.
    logic [KEY_W-1:0]   elem_q_reg;
    logic [KEY_W-1:0]   key_q_reg;
    logic [COUNT_W-1:0] cnt_q_reg;
    logic [COUNT_W-1:0] c_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic               add_reg;

    // Result registers.
    logic [SUM_W-1:0]   cube_sum_reg;
    logic               bad_query_reg;

    // Step selection.
    logic [WIN_W-1:0]   step_pos;
    logic [WIN_W-1:0]   wl_step, wr_step;
    logic               step_add;

    // Count update.
    logic [COUNT_W-1:0] c_new;
    logic [SUM_W-1:0]   sq3, c3, delta_inc, delta_dec;
    logic               bad_in;
    logic               pos_ok_in;

    // Range check of an incoming request.
    always_comb
    begin
        bad_in = (left > right)
              || ({1'b0, right} >= element_count)
              || (32'(right) >= ARRAY_DEPTH);
        pos_ok_in = (32'(position) < ARRAY_DEPTH);
    end

    // Capture the request; a load drains the window to an empty one at its right end.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_load_reg <= (command == CMD_LOAD);
            load_ok_reg <= pos_ok_in;
            bad_reg     <= bad_in;
            pos_reg     <= ADDR_W'(position);
            key_reg     <= key;
            if (command == CMD_LOAD)
            begin
                left_reg <= wr_reg;
                end_reg  <= wr_reg;
            end
            else
            begin
                left_reg <= WIN_W'(left);
                end_reg  <= WIN_W'(right) + WIN_W'(1);
            end
        end
    end

    // Pick the next window move: grow left, grow right, shrink left, shrink right.
    always_comb
    begin
        wl_step  = wl_reg;
        wr_step  = wr_reg;
        step_pos = wl_reg;
        step_add = 1'b0;
        priority if (wl_reg > left_reg)
        begin
            wl_step  = wl_reg - WIN_W'(1);
            step_pos = wl_reg - WIN_W'(1);
            step_add = 1'b1;
        end
        else if (wr_reg < end_reg)
        begin
            wr_step  = wr_reg + WIN_W'(1);
            step_pos = wr_reg;
            step_add = 1'b1;
        end
        else if (wl_reg < left_reg)
        begin
            wl_step  = wl_reg + WIN_W'(1);
            step_pos = wl_reg;
        end
        else
        begin
            wr_step  = wr_reg - WIN_W'(1);
            step_pos = wr_reg - WIN_W'(1);
        end
    end

    // Element store: one write port for loads, one registered read port for steps.
    always_ff @(posedge clk)
    begin
        if (cmd.load_write && load_ok_reg)
        begin
            elem_mem[pos_reg] <= key_reg;
        end
        if (cmd.step)
        begin
            elem_q_reg <= elem_mem[step_pos[ADDR_W-1:0]];
            add_reg    <= step_add;
        end
    end

    // New count and the change of its cube: (c+1)^3-c^3 or c^3-(c-1)^3.
    always_comb
    begin
        sq3       = SUM_W'({sq_reg, 1'b0}) + SUM_W'(sq_reg);
        c3        = SUM_W'({c_reg, 1'b0}) + SUM_W'(c_reg);
        delta_inc = sq3 + c3 + SUM_W'(1);
        delta_dec = sq3 - c3 + SUM_W'(1);
        if (add_reg)
        begin
            c_new    = c_reg + COUNT_W'(1);
            sum_next = sum_reg + delta_inc;
        end
        else if (c_reg != '0)
        begin
            c_new    = c_reg - COUNT_W'(1);
            sum_next = sum_reg - delta_dec;
        end
        else
        begin
            c_new    = c_reg;
            sum_next = sum_reg;
        end
    end

    // Histogram store: cleared by the sweep after reset, updated once per element.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            count_mem[clr_reg] <= '0;
        end
        else if (cmd.update)
        begin
            count_mem[key_q_reg] <= c_new;
        end
        if (cmd.read_count)
        begin
            cnt_q_reg <= count_mem[elem_q_reg];
            key_q_reg <= elem_q_reg;
        end
        if (cmd.square)
        begin
            sq_reg <= cnt_q_reg * cnt_q_reg;
            c_reg  <= cnt_q_reg;
        end
    end

    // Window next values.
    always_comb
    begin
        wl_next = wl_reg;
        wr_next = wr_reg;
        if (cmd.load_write)
        begin
            wl_next = '0;
            wr_next = '0;
        end
        else if (cmd.step)
        begin
            wl_next = wl_step;
            wr_next = wr_step;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= '0;
            wr_reg   <= '0;
            sum_reg  <= '0;
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            wl_reg   <= wl_next;
            wr_reg   <= wr_next;
            done_reg <= cmd.respond;
            if (cmd.load_write)
            begin
                sum_reg <= '0;
            end
            else if (cmd.update)
            begin
                sum_reg <= sum_next;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + KEY_W'(1);
            end
        end
    end

    // Result registers, shown for one cycle under done.
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            cube_sum_reg  <= bad_reg ? '0 : sum_reg;
            bad_query_reg <= bad_reg;
        end
    end

    always_comb
    begin
        status.clear_last = (clr_reg == '1);
        status.is_load    = is_load_reg;
        status.load_ok    = load_ok_reg;
        status.bad        = bad_reg;
        status.need_step  = (wl_reg != left_reg) || (wr_reg != end_reg);
    end

    assign cube_sum  = cube_sum_reg;
    assign bad_query = bad_query_reg;
    assign done      = done_reg;

endmodule

/* src/range_cubed_frequency_sum.sv */
// Range cubed frequency sum.
// A request is taken at a rising edge with start high and busy low. With command
// 0 it loads key at position; with command 1 it asks for the sum of cubed key
// counts over positions left..right. A query gives one result: cube_sum and
// bad_query, held for exactly one cycle while done is high. A load gives none.
// The receiver cannot stall; each result is taken in its done cycle.
// A query moves the window ends element by element, across at most 2048
// elements in all, before done. Each element costs a step decision, a key read,
// a histogram read, a squaring and a histogram write through the element and
// histogram stores, and the next element starts only after that write. A
// rejected query answers without moving the window and changes nothing. A load
// first drains the current window element by element, then writes the key; busy
// is low again after that write.
// The next request is taken in the cycle that done is high.
// After reset busy stays high while a pass clears all 1024 histogram entries.
// element_count is written at byte address 0 of the APB port; pready is always
// high. Write it only while busy is low and no result is pending.
module range_cubed_frequency_sum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic                        command,
    input  logic [rcfs_pkg::POS_W-1:0]  position,
    input  logic [rcfs_pkg::KEY_W-1:0]  key,
    input  logic [rcfs_pkg::POS_W-1:0]  left,
    input  logic [rcfs_pkg::POS_W-1:0]  right,
    output logic [rcfs_pkg::SUM_W-1:0]  cube_sum,
    output logic                        bad_query,
    output logic                        done
);
    import rcfs_pkg::*;

    logic [CFG_W-1:0] element_count_reg;
    logic             cfg_write;
    dp_cmd_t          cmd;
    dp_status_t       status;

    // Configuration register write.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= ELEMENT_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_ELEMENT_COUNT))
        begin
            element_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Configuration register read.
    always_comb
    begin
        if (paddr[2] == REG_ELEMENT_COUNT)
        begin
            prdata = 32'(element_count_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    rcfs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rcfs_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .element_count (element_count_reg),
        .command       (command),
        .position      (position),
        .key           (key),
        .left          (left),
        .right         (right),
        .cube_sum      (cube_sum),
        .bad_query     (bad_query),
        .done          (done)
    );

    // A result only follows a request that was in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // A rejected query reports a zero sum.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_query) |-> (cube_sum == '0))
        else $error("rejected query with nonzero cube_sum");

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule

/* dv/rcfs_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and the request and result channels of the
// range cubed frequency sum block. It keeps its own copy of the key array, the
// key histogram and the sliding window, works out the answer of every
// accepted query and compares it with the answer that the block returns.
module rcfs_checker
    import rcfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic [31:0]      prdata,
    input  logic             pready,
    input  logic             start,
    input  logic             busy,
    input  logic             command,
    input  logic [POS_W-1:0] position,
    input  logic [KEY_W-1:0] key,
    input  logic [POS_W-1:0] left,
    input  logic [POS_W-1:0] right,
    input  logic [SUM_W-1:0] cube_sum,
    input  logic             bad_query,
    input  logic             done,
    output int               errors,
    output int               pending,
    output int               checked,
    output int               rejected,
    output logic [SUM_W-1:0] peak_sum
);

    localparam int KEY_SPACE = 1 << KEY_W;
    localparam logic [2:0] ELEMENT_COUNT_ADDR = {REG_ELEMENT_COUNT, 2'b00};
    // The running sum is kept 40 bits wide; only the low SUM_W bits are visible.
    localparam longint unsigned TOTAL_MASK = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             bad;
    } cube_answer_t;

    cube_answer_t       answer_q[$];
    logic [KEY_W-1:0]   stored_key [ARRAY_DEPTH];
    logic [COUNT_W-1:0] key_tally [KEY_SPACE];
    int unsigned        win_lo;
    int unsigned        win_hi;
    longint unsigned    cube_total;
    logic [CFG_W-1:0]   limit;
    int                 fail_total;
    int                 answer_total;
    int                 reject_total;
    logic [SUM_W-1:0]   sum_peak;

    function automatic longint unsigned cubed(input longint unsigned c);
        return c * c * c;
    endfunction

    // Add or remove the element at pos from the histogram and the cube sum.
    task automatic tally_step(input int unsigned pos, input bit grow);
        logic [KEY_W-1:0] k;
        if (pos < ARRAY_DEPTH)
        begin
            k = stored_key[pos];
            cube_total = cube_total - cubed(longint'(key_tally[k]));
            if (grow)
                key_tally[k] = key_tally[k] + 1'b1;
            else if (key_tally[k] != '0)
                key_tally[k] = key_tally[k] - 1'b1;
            cube_total = (cube_total + cubed(longint'(key_tally[k]))) & TOTAL_MASK;
        end
    endtask

    // Empty the window and the histogram.
    task automatic clear_window();
        foreach (key_tally[i])
            key_tally[i] = '0;
        win_lo = 0;
        win_hi = 0;
        cube_total = 0;
    endtask

    // Slide the window to lo..hi, growing before shrinking, and give the answer.
    task automatic predict_query(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
                                 output cube_answer_t res);
        int unsigned stop;
        if (lo > hi || hi >= limit || hi >= ARRAY_DEPTH)
        begin
            res.sum = '0;
            res.bad = 1'b1;
        end
        else
        begin
            stop = hi + 1;
            while (win_lo > lo)
            begin
                win_lo--;
                tally_step(win_lo, 1'b1);
            end
            while (win_hi < stop)
            begin
                tally_step(win_hi, 1'b1);
                win_hi++;
            end
            while (win_lo < lo)
            begin
                tally_step(win_lo, 1'b0);
                win_lo++;
            end
            while (win_hi > stop)
            begin
                win_hi--;
                tally_step(win_hi, 1'b0);
            end
            res.sum = cube_total[SUM_W-1:0];
            res.bad = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cube_answer_t want;
        if (!rst_n)
        begin
            answer_q.delete();
            foreach (stored_key[i])
                stored_key[i] = '0;
            clear_window();
            limit = ELEMENT_COUNT_RESET;
            fail_total = 0;
            answer_total = 0;
            reject_total = 0;
            sum_peak = '0;
        end
        else
        begin
            // Configuration writes and read-back.
            if (psel && penable && pready)
            begin
                if (pwrite && paddr == ELEMENT_COUNT_ADDR)
                    limit = pwdata[CFG_W-1:0];
                else if (!pwrite && paddr == ELEMENT_COUNT_ADDR && prdata !== 32'(limit))
                begin
                    $display("%0t: element_count read back: expected %0d, got %0d",
                             $time, limit, prdata);
                    fail_total++;
                end
            end

            // A returned answer is matched against the oldest open query.
            if (done)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: answer with no open query: cube_sum %0d, bad_query %0b",
                             $time, cube_sum, bad_query);
                    fail_total++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (cube_sum !== want.sum)
                    begin
                        $display("%0t: cube_sum mismatch: expected %0d, got %0d",
                                 $time, want.sum, cube_sum);
                        fail_total++;
                    end
                    if (bad_query !== want.bad)
                    begin
                        $display("%0t: bad_query mismatch: expected %0b, got %0b",
                                 $time, want.bad, bad_query);
                        fail_total++;
                    end
                    answer_total++;
                    if (want.bad)
                        reject_total++;
                    else if (want.sum > sum_peak)
                        sum_peak = want.sum;
                end
            end

            // An accepted request updates the array or opens a query.
            if (start && !busy)
            begin
                if (command == CMD_LOAD)
                begin
                    stored_key[position] = key;
                    clear_window();
                end
                else
                begin
                    predict_query(left, right, want);
                    answer_q.push_back(want);
                end
            end
        end

        errors   <= fail_total;
        pending  <= answer_q.size();
        checked  <= answer_total;
        rejected <= reject_total;
        peak_sum <= sum_peak;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import rcfs_pkg::*;

    // A load may drain a full window, one element at a time.
    localparam int LOAD_SETTLE  = 5 * ARRAY_DEPTH + 16;
    // Random loads grow the loaded run from position 0 up to about this size.
    localparam int REGION_LIMIT = 96;
    // Length of the run of one key at the end of the test.
    localparam int FILL_RUN     = 32;
    localparam int TIMEOUT_NS   = 500_000_000;
    localparam logic [2:0] ELEMENT_COUNT_ADDR = {REG_ELEMENT_COUNT, 2'b00};
    localparam logic [KEY_W-1:0] KEY_TOP = '1;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             start = 1'b0;
    logic             busy;
    logic             command = CMD_LOAD;
    logic [POS_W-1:0] position = '0;
    logic [KEY_W-1:0] key = '0;
    logic [POS_W-1:0] left = '0;
    logic [POS_W-1:0] right = '0;
    logic [SUM_W-1:0] cube_sum;
    logic             bad_query;
    logic             done;

    int               errors;
    int               pending;
    int               checked;
    int               rejected;
    logic [SUM_W-1:0] peak_sum;

    // Stimulus bookkeeping: which positions hold a key, and how long the run of
    // loaded positions from 0 is. Valid queries stay inside that run.
    bit               written [ARRAY_DEPTH];
    int               loaded_run = 0;
    logic [CFG_W-1:0] count_limit = ELEMENT_COUNT_RESET;
    bit               steady = 1'b0;
    int               loads_sent = 0;
    int               queries_sent = 0;
    int               settings_used = 0;

    always #5 clk = ~clk;

    range_cubed_frequency_sum u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .position  (position),
        .key       (key),
        .left      (left),
        .right     (right),
        .cube_sum  (cube_sum),
        .bad_query (bad_query),
        .done      (done)
    );

    rcfs_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .position  (position),
        .key       (key),
        .left      (left),
        .right     (right),
        .cube_sum  (cube_sum),
        .bad_query (bad_query),
        .done      (done),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .rejected  (rejected),
        .peak_sum  (peak_sum)
    );

    // Present one request after a random gap and hold it until it is taken.
    // Returns right after the accepting edge with start still high.
    task automatic send_request(input logic cmd, input logic [POS_W-1:0] pos,
                                input logic [KEY_W-1:0] k, input logic [POS_W-1:0] lo,
                                input logic [POS_W-1:0] hi);
        int gap;
        if ($urandom_range(0, 24) == 0)
            steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command  <= cmd;
        position <= pos;
        key      <= k;
        left     <= lo;
        right    <= hi;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Load a key; the range fields carry noise that the block must ignore.
    task automatic send_load(input int pos, input int k);
        send_request(CMD_LOAD, POS_W'(pos), KEY_W'(k), POS_W'($urandom), POS_W'($urandom));
        written[pos] = 1'b1;
        while (loaded_run < ARRAY_DEPTH && written[loaded_run])
            loaded_run++;
        loads_sent++;
    endtask

    // Ask a range query; the load fields carry noise.
    task automatic send_query(input int lo, input int hi);
        send_request(CMD_QUERY, POS_W'($urandom), KEY_W'($urandom), POS_W'(lo), POS_W'(hi));
        queries_sent++;
    endtask

    // Mostly valid ranges inside the loaded run, the rest reversed or past the end.
    task automatic random_query();
        int span;
        int lo;
        int hi;
        span = (loaded_run < count_limit) ? loaded_run : count_limit;
        if (span > 0 && $urandom_range(0, 4) != 0)
        begin
            hi = $urandom_range(0, span - 1);
            lo = $urandom_range(0, hi);
        end
        else if (count_limit <= ARRAY_DEPTH - 1 && $urandom_range(0, 1) == 1)
        begin
            hi = $urandom_range(count_limit, ARRAY_DEPTH - 1);
            lo = $urandom_range(0, ARRAY_DEPTH - 1);
        end
        else
        begin
            hi = $urandom_range(0, ARRAY_DEPTH - 2);
            lo = $urandom_range(hi + 1, ARRAY_DEPTH - 1);
        end
        send_query(lo, hi);
    endtask

    // Stop sending and wait until every open query is answered and the block
    // is idle. With settle set, also wait out the longest possible load drain.
    task automatic drain_results(input bit settle);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        if (settle)
            repeat (LOAD_SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // One APB transfer to element_count: setup cycle, then access cycle.
    task automatic apb_access(input bit wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ELEMENT_COUNT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write element_count with noise in the unused upper bits, then read it back.
    task automatic program_limit(input int value);
        logic [31:0] data;
        data = $urandom;
        data[CFG_W-1:0] = CFG_W'(value);
        apb_access(1'b1, data);
        apb_access(1'b0, '0);
        count_limit = CFG_W'(value);
        settings_used++;
    endtask

    initial
    begin
        int phase_limit [5];
        int pick;
        int pos;
        int k;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait out the histogram clearing pass, then check the reset value.
        drain_results(1'b1);
        apb_access(1'b0, '0);

        // Directed: a reversed range on an empty array, then a small array with
        // extreme and repeated keys, queries that move both window ends either way,
        // and a load into a live window.
        send_query(ARRAY_DEPTH - 1, 0);
        send_load(0, KEY_TOP);
        send_load(1, 0);
        send_load(2, KEY_TOP);
        send_load(3, KEY_TOP);
        send_load(4, 5);
        send_load(5, 5);
        send_load(6, 5);
        send_load(7, 5);
        send_load(8, 0);
        send_load(9, 10'h2AA);
        send_load(10, 10'h155);
        send_load(11, KEY_TOP);
        send_query(0, 0);
        send_query(0, 11);
        send_query(4, 7);
        send_query(2, 9);
        send_query(11, 11);
        send_query(3, 3);
        send_query(5, 2);
        send_load(4, KEY_TOP);
        send_query(0, 11);

        // Directed: ranges that run past element_count, down to a count of zero.
        drain_results(1'b1);
        program_limit(12);
        send_query(0, 12);
        send_query(11, 11);
        drain_results(1'b1);
        program_limit(1);
        send_query(0, 0);
        send_query(0, 1);
        drain_results(1'b1);
        program_limit(0);
        send_query(0, 0);

        // Random phases, each under its own element_count.
        phase_limit[0] = ARRAY_DEPTH;
        phase_limit[1] = $urandom_range(2, 100);
        phase_limit[2] = (1 << CFG_W) - 1;
        phase_limit[3] = 1;
        phase_limit[4] = $urandom_range(2, 100);
        for (int phase = 0; phase < 5; phase++)
        begin
            drain_results(1'b1);
            program_limit(phase_limit[phase]);
            for (int n = 0; n < 44; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    drain_results(1'b0);
                if ($urandom_range(0, 9) < 3)
                begin
                    // Extend the loaded run, rewrite inside it, or write anywhere.
                    pick = $urandom_range(0, 4);
                    if (pick < 2 && loaded_run < REGION_LIMIT)
                        pos = loaded_run;
                    else if (pick < 4 && loaded_run > 0)
                        pos = $urandom_range(0, loaded_run - 1);
                    else
                        pos = $urandom_range(0, ARRAY_DEPTH - 1);
                    k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7)
                                                    : $urandom_range(0, ARRAY_DEPTH - 1);
                    send_load(pos, k);
                end
                else
                begin
                    random_query();
                end
            end
        end

        // A run of one key from position 0: its count grows with the window, and
        // the window sweeps the run end to end in both directions.
        drain_results(1'b1);
        program_limit(ARRAY_DEPTH);
        for (int p = 0; p < FILL_RUN; p++)
            send_load(p, KEY_TOP);
        send_query(0, FILL_RUN - 1);
        send_query(FILL_RUN - 1, FILL_RUN - 1);
        send_query(0, FILL_RUN - 1);
        send_query(FILL_RUN / 2, FILL_RUN - 1);
        send_query(0, FILL_RUN / 2 - 1);
        for (int n = 0; n < 4; n++)
            send_load($urandom_range(0, ARRAY_DEPTH - 1), $urandom_range(0, ARRAY_DEPTH - 1));
        for (int n = 0; n < 6; n++)
            random_query();

        drain_results(1'b1);
        $display("Sent %0d loads and %0d range queries under %0d element_count settings.",
                 loads_sent, queries_sent, settings_used);
        $display("Checked %0d answers, %0d rejected ranges; largest cube sum %0d.",
                 checked, rejected, peak_sum);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Run did not finish in time; %0d answers still open.", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* range_cubed_frequency_sum.f */
src/rcfs_pkg.sv
src/rcfs_ctrl.sv
src/rcfs_dp.sv
src/range_cubed_frequency_sum.sv
dv/rcfs_checker.sv
dv/tb_top.sv
